/* rtl/icv_pkg.sv */
// shared types and constants for the internet checksum verifier
`default_nettype none

package icv_pkg;

	localparam int LENGTH_BITS_DEFAULT = 16;

	typedef enum logic {
		CMD_ADDRESS = 1'b0,
		CMD_DATA    = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] address_word;
		logic [7:0]  data_byte;
		logic [7:0]  protocol;
		logic        last;
	} item_t;

	typedef struct packed {
		logic [15:0] checksum_value;
		logic        checksum_ok;
		logic        length_overflow;
	} result_t;

endpackage

`default_nettype wire

/* rtl/icv_accum.sv */
// packet state and one's-complement sum datapath of the checksum verifier
`default_nettype none

module icv_accum #(
	parameter int LENGTH_BITS = icv_pkg::LENGTH_BITS_DEFAULT
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  var  icv_pkg::item_t  item,
	input  wire logic            use_pseudo,
	output var  icv_pkg::result_t result
);
	import icv_pkg::*;

	localparam logic [15:0] SUM_MASK = 16'hFFFF;

	logic [15:0]            sum_q;
	logic [7:0]             held_q;
	logic                   pending_q;
	logic [LENGTH_BITS-1:0] count_q;
	logic                   sat_q;

	logic                   is_data;
	logic                   is_last;
	logic                   at_limit;
	logic [LENGTH_BITS-1:0] count_next;
	logic [31:0]            count_ext;
	logic [15:0]            term_a;
	logic [15:0]            term_b;
	logic [15:0]            term_c;
	logic [15:0]            term_d;
	logic [18:0]            raw_sum;
	logic [15:0]            folded;
	logic [15:0]            value;

	function automatic logic [15:0] fold19(input logic [18:0] s);
		logic [16:0] f1;
		f1 = {1'b0, s[15:0]} + 17'(s[18:16]);
		return f1[15:0] + 16'(f1[16]);
	endfunction

	assign is_data    = (item.cmd == CMD_DATA);
	assign is_last    = is_data && item.last;
	assign at_limit   = &count_q;
	assign count_next = at_limit ? count_q : count_q + LENGTH_BITS'(1);
	assign count_ext  = 32'(count_next);

	// operands for this beat
	always_comb begin
		term_a = '0;
		term_b = '0;
		term_c = '0;
		term_d = '0;
		if (!is_data) begin
			term_a = item.address_word[31:16];
			term_b = item.address_word[15:0];
		end else begin
			if (pending_q) begin
				term_a = {held_q, item.data_byte};
			end else if (item.last) begin
				term_a = {item.data_byte, 8'h00};
			end
			if (item.last && use_pseudo) begin
				term_b = count_ext[31:16];
				term_c = count_ext[15:0];
				term_d = {8'h00, item.protocol};
			end
		end
	end

	assign raw_sum = 19'(sum_q) + 19'(term_a) + 19'(term_b) + 19'(term_c) + 19'(term_d);
	assign folded  = fold19(raw_sum);
	assign value   = ~folded;

	assign result.checksum_value  = value;
	assign result.checksum_ok     = (value == 16'h0000) || (value == SUM_MASK);
	assign result.length_overflow = sat_q || at_limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			held_q    <= '0;
			pending_q <= 1'b0;
			count_q   <= '0;
			sat_q     <= 1'b0;
		end else if (step) begin
			if (!is_data) begin
				sum_q <= folded;
			end else if (is_last) begin
				sum_q     <= '0;
				held_q    <= '0;
				pending_q <= 1'b0;
				count_q   <= '0;
				sat_q     <= 1'b0;
			end else begin
				sum_q     <= folded;
				held_q    <= pending_q ? 8'h00 : item.data_byte;
				pending_q <= !pending_q;
				count_q   <= count_next;
				sat_q     <= sat_q || at_limit;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$past(step && is_last) |-> (sum_q == 16'h0000) && !pending_q && !sat_q)
		else $error("packet state not cleared after last beat");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |-> &count_q)
		else $error("saturation flag set below count limit");

	a_held_zero_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!pending_q |-> (held_q == 8'h00))
		else $error("held byte nonzero without pending byte");

endmodule

`default_nettype wire

/* rtl/internet_checksum_verifier_core.sv */
// top level of the internet checksum verifier: handshakes, stage register, result register
// a last data beat goes to the stage register and its result then to the result register
// throughput: one beat per cycle, each a single end-around-carry sum into the state, but
// the input stage waits only while it holds a last beat and the result register is stalled
// reset: asynchronous, clears sum, pending byte, count, use_pseudo and all valid flags
`default_nettype none

module internet_checksum_verifier_core #(
	parameter int LENGTH_BITS = icv_pkg::LENGTH_BITS_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic             cfg_wr_data,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  var  icv_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output icv_pkg::result_t      result
);
	import icv_pkg::*;

	logic    use_pseudo_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    is_res_s1;
	logic    go_s1;
	logic    result_valid_q;
	result_t result_q;
	result_t result_comb;

	assign is_res_s1  = (item_s1.cmd == CMD_DATA) && item_s1.last;
	assign go_s1      = valid_s1 && (!is_res_s1 || !result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_pseudo_q <= 1'b0;
		end else if (cfg_wr_en) begin
			use_pseudo_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	icv_accum #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (go_s1),
		.item       (item_s1),
		.use_pseudo (use_pseudo_q),
		.result     (result_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (go_s1 && is_res_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && is_res_s1) begin
			result_q <= result_comb;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_stall_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && is_res_s1 && result_valid_q)
		else $error("input stalled without a blocked result");

	a_result_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(go_s1 && is_res_s1))
		else $error("result beat without a last data beat");

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q |-> !item_stall)
		else $error("input stalled while result register empty");

endmodule

`default_nettype wire

/* bench/internet_checksum_verifier_core_tb.sv */
// testbench for internet_checksum_verifier_core: random and directed packets vs a local predictor
`default_nettype none

module internet_checksum_verifier_core_tb;
	import icv_pkg::*;

	localparam int LEN_BITS = LENGTH_BITS_DEFAULT;
	localparam logic [63:0] TALLY_MAX = (64'd1 << LEN_BITS) - 64'd1;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	typedef struct {
		item_t       beat;
		int unsigned gap_after;
	} queued_beat_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cfg_wr_en = 1'b0;
	logic    cfg_wr_data = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_stall;
	item_t   item = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	queued_beat_t beat_queue[$];
	result_t      expected_checksums[$];

	// predictor state
	logic        pseudo_mode = 1'b0;
	logic [15:0] sum_acc = '0;
	logic [7:0]  held_hi = '0;
	logic        hi_pending = 1'b0;
	logic [63:0] byte_tally = '0;
	logic        tally_sat = 1'b0;

	int unsigned beats_queued = 0;
	int unsigned beats_accepted = 0;
	int unsigned address_beats = 0;
	int unsigned results_checked = 0;
	int unsigned overflow_seen = 0;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_off = 0;
	int unsigned cur_gap = 0;
	int unsigned rx_wait = 0;
	bit          rx_calm = 1'b0;
	bit          calm = 1'b0;
	queued_beat_t upcoming;

	internet_checksum_verifier_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #1 clk = ~clk;

	function automatic logic [15:0] ones_add(logic [15:0] acc, logic [15:0] w);
		logic [16:0] s;
		s = {1'b0, acc} + {1'b0, w};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	function automatic void fold_beat(item_t b);
		result_t r;
		if (b.cmd == CMD_ADDRESS) begin
			address_beats++;
			sum_acc = ones_add(sum_acc, b.address_word[31:16]);
			sum_acc = ones_add(sum_acc, b.address_word[15:0]);
			return;
		end
		if (byte_tally >= TALLY_MAX)
			tally_sat = 1'b1;
		else
			byte_tally++;
		if (hi_pending) begin
			sum_acc = ones_add(sum_acc, {held_hi, b.data_byte});
			hi_pending = 1'b0;
			held_hi = '0;
		end else begin
			held_hi = b.data_byte;
			hi_pending = 1'b1;
		end
		if (!b.last)
			return;
		if (hi_pending)
			sum_acc = ones_add(sum_acc, {held_hi, 8'h00});
		if (pseudo_mode) begin
			sum_acc = ones_add(sum_acc, byte_tally[31:16]);
			sum_acc = ones_add(sum_acc, byte_tally[15:0]);
			sum_acc = ones_add(sum_acc, {8'h00, b.protocol});
		end
		r.checksum_value = ~sum_acc;
		r.checksum_ok = (r.checksum_value == 16'h0000) || (r.checksum_value == 16'hFFFF);
		r.length_overflow = tally_sat;
		expected_checksums.push_back(r);
		sum_acc = '0;
		held_hi = '0;
		hi_pending = 1'b0;
		byte_tally = '0;
		tally_sat = 1'b0;
	endfunction

	function automatic void check_result(result_t got);
		result_t want;
		if (expected_checksums.size() == 0) begin
			$display("%0t: unexpected result beat, actual %h", $time, got);
			errors++;
			return;
		end
		want = expected_checksums.pop_front();
		results_checked++;
		if (got.length_overflow)
			overflow_seen++;
		if (got.checksum_value !== want.checksum_value) begin
			$display("%0t: checksum_value expected %h actual %h", $time,
				want.checksum_value, got.checksum_value);
			errors++;
		end
		if (got.checksum_ok !== want.checksum_ok) begin
			$display("%0t: checksum_ok expected %b actual %b", $time,
				want.checksum_ok, got.checksum_ok);
			errors++;
		end
		if (got.length_overflow !== want.length_overflow) begin
			$display("%0t: length_overflow expected %b actual %b", $time,
				want.length_overflow, got.length_overflow);
			errors++;
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			hold_off = 0;
		end else begin
			if (item_valid && !item_stall) begin
				fold_beat(item);
				beats_accepted++;
				hold_off = cur_gap;
			end
			if (!item_valid || !item_stall) begin
				if (hold_off != 0) begin
					hold_off--;
					item_valid <= 1'b0;
				end else if (beat_queue.size() != 0) begin
					upcoming = beat_queue.pop_front();
					item <= upcoming.beat;
					item_valid <= 1'b1;
					cur_gap = upcoming.gap_after;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			rx_wait = 0;
		end else begin
			if (result_valid && !result_stall) begin
				check_result(result);
				if ($urandom_range(0, 15) == 0)
					rx_calm = !rx_calm;
				rx_wait = rx_calm ? 0 : $urandom_range(0, 19);
			end else if (rx_wait != 0) begin
				rx_wait--;
			end
			result_stall <= (rx_wait != 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("internet_checksum_verifier_core_tb NOT OK");
			$finish;
		end
	end

	function automatic void push_beat(cmd_t c, logic [31:0] w, logic [7:0] b,
		logic [7:0] p, logic l);
		queued_beat_t e;
		e.beat.cmd = c;
		e.beat.address_word = w;
		e.beat.data_byte = b;
		e.beat.protocol = p;
		e.beat.last = l;
		e.gap_after = calm ? 0 : $urandom_range(0, 19);
		beat_queue.push_back(e);
		beats_queued++;
	endfunction

	function automatic void queue_packet(int unsigned n_addr, int unsigned n_bytes, bit mid_addr);
		for (int unsigned i = 0; i < n_addr; i++)
			push_beat(CMD_ADDRESS, $urandom, 8'($urandom), 8'($urandom),
				$urandom_range(0, 7) == 0);
		for (int unsigned i = 0; i < n_bytes; i++) begin
			// address beat while a high byte is held
			if (mid_addr && i[0] && $urandom_range(0, 2) == 0)
				push_beat(CMD_ADDRESS, $urandom, 8'($urandom), 8'($urandom),
					1'($urandom_range(0, 1)));
			push_beat(CMD_DATA, $urandom, 8'($urandom), 8'($urandom), i == n_bytes - 1);
		end
	endfunction

	function automatic void random_phase(int unsigned budget);
		int unsigned start;
		int unsigned n_addr;
		start = beats_queued;
		while (beats_queued - start < budget) begin
			calm = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 3))
				0: n_addr = 0;
				1: n_addr = 2;
				2: n_addr = 8;
				default: n_addr = $urandom_range(1, 3);
			endcase
			case ($urandom_range(0, 9))
				7: begin
					queue_packet(0, $urandom_range(25, 120), 1'b1);
				end
				8: begin
					// stray address beats, last set or not
					repeat ($urandom_range(1, 3))
						push_beat(CMD_ADDRESS, $urandom, 8'($urandom), 8'($urandom),
							1'($urandom_range(0, 1)));
				end
				9: begin
					// unterminated run, absorbed by the next packet
					repeat ($urandom_range(1, 5))
						push_beat(CMD_DATA, $urandom, 8'($urandom), 8'($urandom), 1'b0);
				end
				default: begin
					queue_packet(n_addr, $urandom_range(1, 24), 1'($urandom_range(0, 1)));
				end
			endcase
		end
		calm = 1'b0;
		queue_packet(0, $urandom_range(1, 4), 1'b0);
	endfunction

	task automatic drain();
		while (beats_accepted != beats_queued)
			@(posedge clk);
		while (expected_checksums.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_pseudo(logic v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		pseudo_mode = v;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// plain mode out of reset
		push_beat(CMD_ADDRESS, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1);
		push_beat(CMD_ADDRESS, 32'h0000_0000, 8'h00, 8'h00, 1'b0);
		push_beat(CMD_DATA, 32'h0, 8'h00, 8'h00, 1'b0);
		push_beat(CMD_DATA, 32'h0, 8'hFF, 8'h00, 1'b0);
		push_beat(CMD_DATA, 32'h0, 8'h80, 8'h00, 1'b0);
		push_beat(CMD_ADDRESS, 32'h8000_0001, 8'h00, 8'h00, 1'b0);
		push_beat(CMD_DATA, 32'hFFFF_FFFF, 8'h7F, 8'hFF, 1'b1);
		push_beat(CMD_DATA, 32'h0, 8'hFF, 8'h00, 1'b1);
		push_beat(CMD_DATA, 32'h0, 8'hFF, 8'h00, 1'b0);
		push_beat(CMD_DATA, 32'h0, 8'hFF, 8'h00, 1'b1);
		push_beat(CMD_DATA, 32'h0, 8'h00, 8'h00, 1'b1);
		random_phase(150);
		drain();

		write_pseudo(1'b1);
		push_beat(CMD_ADDRESS, 32'hC0A8_0001, 8'h00, 8'h00, 1'b0);
		push_beat(CMD_ADDRESS, 32'hC0A8_0002, 8'h00, 8'h00, 1'b0);
		push_beat(CMD_DATA, 32'h0, 8'h45, 8'h00, 1'b0);
		push_beat(CMD_DATA, 32'h0, 8'h00, 8'h00, 1'b0);
		push_beat(CMD_DATA, 32'h0, 8'h01, 8'h11, 1'b1);
		push_beat(CMD_DATA, 32'h0, 8'h00, 8'hFF, 1'b1);
		push_beat(CMD_DATA, 32'h0, 8'hFF, 8'h00, 1'b1);
		random_phase(200);
		drain();

		write_pseudo(1'b0);
		random_phase(200);
		drain();

		write_pseudo(1'b1);
		random_phase(200);
		drain();

		write_pseudo(1'b0);
		random_phase(200);
		drain();

		repeat (8) @(posedge clk);
		if (expected_checksums.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				expected_checksums.size());
			errors++;
		end
		$display("%0d beats (%0d address words) sent, %0d packet checksums compared",
			beats_accepted, address_beats, results_checked);
		$display("%0d packets hit length saturation, pseudo mode toggled over 5 phases",
			overflow_seen);
		if (errors == 0)
			$display("internet_checksum_verifier_core_tb OK");
		else
			$display("internet_checksum_verifier_core_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
rtl/icv_pkg.sv
rtl/icv_accum.sv
rtl/internet_checksum_verifier_core.sv
bench/internet_checksum_verifier_core_tb.sv
